// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define VFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define VFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ADPCM frame decoder package
// Function codes, sample types, the pipeline tag and the residual and
// saturation helpers shared by the decoder modules.
// ----------------------------------------------------------------------------
package vfd_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_HIST   = 2'd1;
    localparam logic [1:0] FUNC_DECODE = 2'd2;

    localparam int SMP_W     = 16;
    localparam int ACC_W     = 32;
    localparam int RES_SHIFT = 11;
    localparam int GROUP_LEN = 8;

    typedef logic signed [SMP_W-1:0] smp_t;
    typedef logic signed [ACC_W-1:0] acc_t;
    typedef logic [GROUP_LEN-1:0][SMP_W-1:0] group_t;

    localparam smp_t SMP_MAX = smp_t'(16'h7FFF);
    localparam smp_t SMP_MIN = smp_t'(16'h8000);

    typedef struct packed {
        logic       valid;
        logic       first;
        logic       last;
        logic [2:0] slot;
    } mac_tag_t;

    function automatic smp_t residual(input logic [3:0] nib, input logic [3:0] shift);
        logic [SMP_W-1:0] ext;
        ext = {{(SMP_W-4){nib[3]}}, nib};
        return smp_t'(ext << shift);
    endfunction

    function automatic smp_t saturate(input acc_t acc);
        logic [ACC_W-RES_SHIFT-1:0] q;
        q = acc[ACC_W-1:RES_SHIFT];
        if (q[ACC_W-RES_SHIFT-1:SMP_W-1] != {(ACC_W-RES_SHIFT-SMP_W+1){q[SMP_W-1]}})
        begin
            return q[ACC_W-RES_SHIFT-1] ? SMP_MIN : SMP_MAX;
        end
        return smp_t'(q[SMP_W-1:0]);
    endfunction

endpackage

// ===== hw/rtl/vfd_if.sv =====
// ----------------------------------------------------------------------------
// ADPCM frame decoder channels
// Valid/ready channels for command words and decoded sample groups.
// ----------------------------------------------------------------------------
interface vfd_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [6:0]         coef_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] hist_newer;
    logic signed [15:0] hist_older;
    logic [7:0]         frame_header;
    logic [63:0]        frame_data;

    modport source (
        output valid, func, coef_index, coef_value, hist_newer, hist_older,
               frame_header, frame_data,
        input  ready
    );
    modport sink (
        input  valid, func, coef_index, coef_value, hist_newer, hist_older,
               frame_header, frame_data,
        output ready
    );
endinterface

interface vfd_pcm_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_0;
    logic signed [15:0] sample_1;
    logic signed [15:0] sample_2;
    logic signed [15:0] sample_3;
    logic signed [15:0] sample_4;
    logic signed [15:0] sample_5;
    logic signed [15:0] sample_6;
    logic signed [15:0] sample_7;
    logic               last_of_frame;

    modport source (
        output valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, last_of_frame,
        input  ready
    );
    modport sink (
        input  valid, sample_0, sample_1, sample_2, sample_3, sample_4, sample_5,
               sample_6, sample_7, last_of_frame,
        output ready
    );
endinterface

// ===== hw/rtl/vfd_book.sv =====
// ----------------------------------------------------------------------------
// Codebook memory
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module vfd_book
    import vfd_pkg::*;
#(
    parameter int DEPTH = 128,
    parameter int AW    = 7
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  smp_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output smp_t          rd_data
);

    smp_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/vfd_mac.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Registered coefficient product, 32-bit wrapping accumulation, shift and
// saturation of each finished sample into the group buffer.
// ----------------------------------------------------------------------------
module vfd_mac
    import vfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_tag_t tag,
    input  smp_t     coef,
    input  logic     coef_zero,
    input  smp_t     opnd,
    input  smp_t     base,
    output logic     busy,
    output group_t   work
);

    mac_tag_t tag2_reg;
    acc_t     prod_reg;
    smp_t     base2_reg;
    acc_t     acc_reg;
    group_t   work_reg;
    smp_t     coef_eff;
    acc_t     prod_next;
    acc_t     sum_next;

    assign coef_eff  = coef_zero ? smp_t'(0) : coef;
    assign prod_next = acc_t'(coef_eff) * acc_t'(opnd);
    assign sum_next  = (tag2_reg.first ? (acc_t'(base2_reg) <<< RES_SHIFT) : acc_reg)
                       + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
        end
        else
        begin
            tag2_reg <= tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        base2_reg <= base;
        if (tag2_reg.valid)
        begin
            acc_reg <= sum_next;
            if (tag2_reg.last)
            begin
                work_reg[tag2_reg.slot] <= saturate(sum_next);
            end
        end
    end

    assign busy = tag2_reg.valid;
    assign work = work_reg;

endmodule

// ===== hw/rtl/vadpcm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ADPCM frame decoder
// A codebook word load and a history set are each taken in the idle state. A frame
// decode issues 44 codebook reads and products per group of eight samples
// through a single codebook read port and one multiplier, then drains the
// operand, product and accumulate registers and hands the group to the output
// register. The next word is taken once the second group has been handed over,
// later if the output side stalls. The first group may wait in the output
// register while the second one is computed. The codebook is not cleared by
// reset; a frame must only use predictors whose words have been loaded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vadpcm_frame_decoder
    import vfd_pkg::*;
#(
    parameter int NUM_PREDICTORS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    vfd_cmd_if.sink         cmd,
    vfd_pcm_if.source       pcm
);

    localparam int BOOK_DEPTH = NUM_PREDICTORS * 16;
    localparam int BOOK_AW    = $clog2(BOOK_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic [2:0]  pred_reg;
    logic        pred_ok_reg;
    logic [3:0]  shift_reg;
    logic [63:0] data_reg;
    logic        group_reg;
    logic [2:0]  slot_reg;
    logic [3:0]  term_reg;
    smp_t        prev_newer_reg;
    smp_t        prev_older_reg;
    logic        out_valid_reg;
    logic        out_last_reg;
    group_t      out_smp_reg;

    mac_tag_t    tag1_reg;
    smp_t        opnd1_reg;
    smp_t        base1_reg;
    logic        zero1_reg;

    logic        cmd_fire;
    logic        issue;
    logic        last_term;
    logic        load_en;
    logic        mac_busy;
    logic        book_wr;
    logic [31:0] grp_bits;
    smp_t        res [GROUP_LEN];
    logic        row;
    logic [2:0]  col;
    smp_t        opnd;
    smp_t        coef;
    group_t      work;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign issue     = (state_reg == ST_RUN);
    assign last_term = (term_reg == (4'(slot_reg) + 4'd1));
    assign load_en   = (state_reg == ST_WAIT) && !tag1_reg.valid && !mac_busy
                       && (!out_valid_reg || pcm.ready);
    assign book_wr   = cmd_fire && (cmd.func == FUNC_LOAD)
                       && ({1'b0, cmd.coef_index} < 8'(BOOK_DEPTH));

    assign grp_bits = group_reg ? data_reg[31:0] : data_reg[63:32];

    always_comb
    begin
        for (int i = 0; i < GROUP_LEN; i++)
        begin
            res[i] = residual(grp_bits[31-4*i -: 4], shift_reg);
        end
    end

    assign row = (term_reg != 4'd0);
    assign col = (term_reg == 4'd0) ? slot_reg : (slot_reg - 3'(term_reg - 4'd1));

    always_comb
    begin
        case (term_reg)
            4'd0:    opnd = prev_older_reg;
            4'd1:    opnd = prev_newer_reg;
            default: opnd = res[3'(term_reg - 4'd2)];
        endcase
    end

    vfd_book #(
        .DEPTH (BOOK_DEPTH),
        .AW    (BOOK_AW)
    ) u_book (
        .clk     (clk),
        .wr_en   (book_wr),
        .wr_addr (BOOK_AW'(cmd.coef_index)),
        .wr_data (cmd.coef_value),
        .rd_en   (issue && pred_ok_reg),
        .rd_addr (BOOK_AW'({pred_reg, row, col})),
        .rd_data (coef)
    );

    vfd_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag1_reg),
        .coef      (coef),
        .coef_zero (zero1_reg),
        .opnd      (opnd1_reg),
        .base      (base1_reg),
        .busy      (mac_busy),
        .work      (work)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.func == FUNC_DECODE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_term && (slot_reg == 3'd7))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (load_en)
                begin
                    state_next = group_reg ? ST_IDLE : ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            group_reg      <= 1'b0;
            slot_reg       <= 3'd0;
            term_reg       <= 4'd0;
            prev_newer_reg <= '0;
            prev_older_reg <= '0;
            out_valid_reg  <= 1'b0;
            tag1_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            tag1_reg.valid <= issue;
            tag1_reg.first <= (term_reg == 4'd0);
            tag1_reg.last  <= last_term;
            tag1_reg.slot  <= slot_reg;

            if (cmd_fire && (cmd.func == FUNC_HIST))
            begin
                prev_newer_reg <= cmd.hist_newer;
                prev_older_reg <= cmd.hist_older;
            end

            if (cmd_fire && (cmd.func == FUNC_DECODE))
            begin
                group_reg <= 1'b0;
                slot_reg  <= 3'd0;
                term_reg  <= 4'd0;
            end
            else if (issue)
            begin
                if (last_term)
                begin
                    term_reg <= 4'd0;
                    slot_reg <= slot_reg + 3'd1;
                end
                else
                begin
                    term_reg <= term_reg + 4'd1;
                end
            end
            else if (load_en)
            begin
                group_reg <= 1'b1;
                slot_reg  <= 3'd0;
                term_reg  <= 4'd0;
            end

            if (load_en)
            begin
                prev_older_reg <= smp_t'(work[6]);
                prev_newer_reg <= smp_t'(work[7]);
                out_valid_reg  <= 1'b1;
            end
            else if (pcm.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire && (cmd.func == FUNC_DECODE))
        begin
            pred_reg    <= cmd.frame_header[2:0];
            pred_ok_reg <= ({1'b0, cmd.frame_header[2:0]} < 4'(NUM_PREDICTORS));
            shift_reg   <= cmd.frame_header[7:4];
            data_reg    <= cmd.frame_data;
        end
        opnd1_reg <= opnd;
        base1_reg <= res[slot_reg];
        zero1_reg <= !pred_ok_reg;
        if (load_en)
        begin
            out_smp_reg  <= work;
            out_last_reg <= group_reg;
        end
    end

    assign pcm.valid         = out_valid_reg;
    assign pcm.sample_0      = out_smp_reg[0];
    assign pcm.sample_1      = out_smp_reg[1];
    assign pcm.sample_2      = out_smp_reg[2];
    assign pcm.sample_3      = out_smp_reg[3];
    assign pcm.sample_4      = out_smp_reg[4];
    assign pcm.sample_5      = out_smp_reg[5];
    assign pcm.sample_6      = out_smp_reg[6];
    assign pcm.sample_7      = out_smp_reg[7];
    assign pcm.last_of_frame = out_last_reg;

    `VFD_ASSERT(a_ready_pipe_empty, !cmd.ready || (!tag1_reg.valid && !mac_busy), "word taken while pipeline busy")
    `VFD_ASSERT(a_load_no_overwrite, !load_en || !out_valid_reg || pcm.ready, "output group overwritten")
    `VFD_ASSERT(a_first_group_busy, !(out_valid_reg && !out_last_reg) || (state_reg != ST_IDLE), "idle with second group pending")
    `VFD_ASSERT_NEXT(a_decode_starts, cmd_fire && (cmd.func == FUNC_DECODE), issue && (term_reg == 4'd0), "decode did not start issuing")

endmodule
